// ----- hw/rtl/drbf_pkg.sv -----
// Shared types, constants and helpers for the detection row box filter.
// Used by every module of the block; no dependencies.
`default_nettype none

package drbf_pkg;

    localparam int NUM_CLASSES     = 80;
    localparam int COORD_FRAC_BITS = 4;
    localparam int TBL_AW          = $clog2(NUM_CLASSES);

    localparam int VAL_W      = 24;
    localparam int PROB_W     = 17;
    localparam int CLS_W      = 7;
    localparam int POS_W      = 7;
    localparam int COORD_W    = 16;
    localparam int CORNER_W   = 26;
    localparam int PROD_W     = 2 * PROB_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 88;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [POS_W-1:0]   OBJ_POS       = POS_W'(4);
    localparam logic [POS_W-1:0]   FIRST_CLS_POS = POS_W'(5);
    localparam logic [POS_W-1:0]   SIX_LAST_POS  = POS_W'(5);
    localparam logic [POS_W-1:0]   RAW_LAST_POS  = POS_W'(5 + NUM_CLASSES - 1);
    localparam logic [PROB_W-1:0]  PROB_ONE      = PROB_W'(65536);
    localparam logic [PROD_W-1:0]  ROUND_HALF    = PROD_W'(32768);
    localparam logic [COORD_W:0]   MIN_SIZE      = (COORD_W + 1)'(1 << COORD_FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_MODE = 3'd0,
        REG_NET_WIDTH    = 3'd1,
        REG_NET_HEIGHT   = 3'd2,
        REG_CLASS_COUNT  = 3'd3,
        REG_OBJ_MIN      = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic              raw_mode;
        logic [11:0]       net_width;
        logic [11:0]       net_height;
        logic [CLS_W-1:0]  class_count;
        logic [PROB_W-1:0] objectness_min;
    } cfg_t;

    typedef enum logic [1:0] {
        ENT_ROW    = 2'd0,
        ENT_SHORT  = 2'd1,
        ENT_TWRITE = 2'd2
    } ent_kind_t;

    // One queue word: a finished row, a short final row or a threshold write.
    // For a threshold write cls carries the slot and prob the threshold.
    typedef struct packed {
        ent_kind_t                kind;
        logic                     last;
        logic                     raw;
        logic signed [VAL_W-1:0]  c0;
        logic signed [VAL_W-1:0]  c1;
        logic signed [VAL_W-1:0]  c2;
        logic signed [VAL_W-1:0]  c3;
        logic [PROB_W-1:0]        obj;
        logic [PROB_W-1:0]        prob;
        logic signed [VAL_W-1:0]  conf;
        logic signed [VAL_W-1:0]  cls;
    } row_ent_t;

    function automatic logic [PROB_W-1:0] sat_prob(input logic signed [VAL_W-1:0] v);
        logic [PROB_W-1:0] r;
        if (v[VAL_W-1]) begin
            r = '0;
        end else if (v > $signed(VAL_W'(PROB_ONE))) begin
            r = PROB_ONE;
        end else begin
            r = v[PROB_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [CORNER_W-1:0] v,
                                                       input logic [COORD_W-1:0] lim);
        logic [COORD_W-1:0] r;
        if (v[CORNER_W-1]) begin
            r = '0;
        end else if (v[CORNER_W-2:0] > (CORNER_W-1)'(lim)) begin
            r = lim;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/drbf_front.sv -----
// Front end: accepts tensor elements and threshold writes, tracks the row
// position and class argmax, and issues queue words. Depends on drbf_pkg.
`default_nettype none

module drbf_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          raw_mode,
    input  wire logic                          s_accept,
    input  wire logic                          req_type,
    input  wire logic signed [23:0]            value,
    input  wire logic                          last_of_tensor,
    input  wire logic [6:0]                    class_slot,
    input  wire logic [16:0]                   threshold_value,
    output logic                               push,
    output drbf_pkg::row_ent_t                 push_ent
);
    import drbf_pkg::*;

    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [VAL_W-1:0] coord_reg [4];
    logic signed [VAL_W-1:0] coord_next [4];
    logic [PROB_W-1:0]       obj_reg, obj_next;
    logic signed [VAL_W-1:0] conf_reg, conf_next;
    logic [PROB_W-1:0]       best_prob_reg, best_prob_next;
    logic [CLS_W-1:0]        best_class_reg, best_class_next;

    logic [POS_W-1:0]  last_pos;
    logic              final_elem;
    logic              is_elem;
    logic [PROB_W-1:0] prob_in;
    logic [PROB_W-1:0] base_prob;
    logic [CLS_W-1:0]  base_class;
    logic              take;

    assign last_pos   = raw_mode ? RAW_LAST_POS : SIX_LAST_POS;
    assign final_elem = (pos_reg >= last_pos);
    assign is_elem    = s_accept && !req_type;
    assign prob_in    = sat_prob(value);
    // restart the argmax on the first class score of a row
    assign base_prob  = (pos_reg == FIRST_CLS_POS) ? '0 : best_prob_reg;
    assign base_class = (pos_reg == FIRST_CLS_POS) ? '0 : best_class_reg;
    assign take       = (prob_in > base_prob);

    always_comb begin
        pos_next        = pos_reg;
        coord_next      = coord_reg;
        obj_next        = obj_reg;
        conf_next       = conf_reg;
        best_prob_next  = best_prob_reg;
        best_class_next = best_class_reg;
        if (is_elem) begin
            if (pos_reg < OBJ_POS) begin
                coord_next[pos_reg[1:0]] = value;
            end else if (pos_reg == OBJ_POS) begin
                obj_next  = prob_in;
                conf_next = value;
            end else if (raw_mode) begin
                best_prob_next  = take ? prob_in : base_prob;
                best_class_next = take ? CLS_W'(pos_reg - FIRST_CLS_POS) : base_class;
            end
            pos_next = (final_elem || last_of_tensor) ? '0 : POS_W'(pos_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            coord_reg      <= '{default: '0};
            obj_reg        <= '0;
            conf_reg       <= '0;
            best_prob_reg  <= '0;
            best_class_reg <= '0;
        end else begin
            pos_reg        <= pos_next;
            coord_reg      <= coord_next;
            obj_reg        <= obj_next;
            conf_reg       <= conf_next;
            best_prob_reg  <= best_prob_next;
            best_class_reg <= best_class_next;
        end
    end

    // drop threshold writes to slots beyond the table here
    assign push = s_accept && (req_type ? (32'(class_slot) < NUM_CLASSES)
                                        : (final_elem || last_of_tensor));

    always_comb begin
        push_ent.kind = req_type ? ENT_TWRITE : (final_elem ? ENT_ROW : ENT_SHORT);
        push_ent.last = last_of_tensor;
        push_ent.raw  = raw_mode;
        push_ent.c0   = coord_reg[0];
        push_ent.c1   = coord_reg[1];
        push_ent.c2   = coord_reg[2];
        push_ent.c3   = coord_reg[3];
        push_ent.obj  = obj_reg;
        push_ent.prob = req_type ? threshold_value : best_prob_next;
        push_ent.conf = conf_reg;
        if (req_type) begin
            push_ent.cls = VAL_W'(class_slot);
        end else if (raw_mode) begin
            push_ent.cls = VAL_W'(best_class_next);
        end else begin
            push_ent.cls = value;
        end
    end

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= RAW_LAST_POS)
        else $error("row position ran past the raw row length");

endmodule

`default_nettype wire

// ----- hw/rtl/drbf_queue.sv -----
// Short FIFO of row words between the front end and the back end.
// Depends on drbf_pkg for the word type and depth.
`default_nettype none

module drbf_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire drbf_pkg::row_ent_t push_ent,
    output logic                    full,
    input  wire logic               pop,
    output drbf_pkg::row_ent_t      head,
    output logic                    empty
);
    import drbf_pkg::*;

    row_ent_t        mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == (Q_AW + 1)'(Q_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? Q_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? Q_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = (Q_AW + 1)'(cnt_reg + (Q_AW + 1)'(push) - (Q_AW + 1)'(pop));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_ent;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("word pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("word popped from an empty queue");

endmodule

`default_nettype wire

// ----- hw/rtl/drbf_back.sv -----
// Back end: threshold table, confidence and class checks, corner clamp and
// the output register. Depends on drbf_pkg.
`default_nettype none

module drbf_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire drbf_pkg::cfg_t                    cfg,
    input  wire logic                              q_empty,
    input  wire drbf_pkg::row_ent_t                q_head,
    output logic                                   q_pop,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [drbf_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tlast,
    output logic [0:0]                             m_tuser
);
    import drbf_pkg::*;

    typedef struct packed {
        ent_kind_t                  kind;
        logic                       last;
        logic                       raw;
        logic                       cls_ok;
        logic [PROB_W-1:0]          thr;
        logic [PROD_W-1:0]          prod;
        logic [PROB_W-1:0]          obj;
        logic signed [VAL_W-1:0]    conf;
        logic [CLS_W-1:0]           cls;
        logic signed [CORNER_W-1:0] x1;
        logic signed [CORNER_W-1:0] y1;
        logic signed [CORNER_W-1:0] x2;
        logic signed [CORNER_W-1:0] y2;
    } chk_t;

    typedef struct packed {
        logic               last;
        logic               keep;
        logic [COORD_W-1:0] l;
        logic [COORD_W-1:0] t;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] b;
        logic [PROB_W-1:0]  score;
        logic [CLS_W-1:0]   cls;
    } clp_t;

    logic adv;

    // threshold table
    logic [PROB_W-1:0]      tbl_mem [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] tbl_vld_reg;
    logic [TBL_AW-1:0]      tbl_addr;
    logic [PROB_W-1:0]      tbl_rd_reg;
    logic                   tbl_hit_reg;
    logic                   is_twrite;

    // stage 1
    logic                       s1_vld_reg;
    row_ent_t                   s1_reg;
    logic                       s1_cls_ok;
    logic signed [CORNER_W-1:0] c0e, c1e, c2e, c3e;
    chk_t                       s2_next;

    // stage 2
    logic                       s2_vld_reg;
    chk_t                       s2_reg;
    logic [PROB_W-1:0]          conf_raw;
    logic                       drop;
    logic [COORD_W-1:0]         lim_x, lim_y;
    clp_t                       s3_next;

    // stage 3
    logic                       s3_vld_reg;
    clp_t                       s3_reg;
    logic signed [COORD_W:0]    dw, dh;
    logic                       box_ok;

    // output register
    logic                       m_tvalid_reg;
    logic [M_TDATA_W-1:0]       m_tdata_reg;
    logic                       m_tlast_reg;
    logic                       m_box_reg;

    assign adv       = !m_tvalid_reg || m_tready;
    assign q_pop     = !q_empty && adv;
    assign tbl_addr  = q_head.cls[TBL_AW-1:0];
    assign is_twrite = (q_head.kind == ENT_TWRITE);

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            if (is_twrite) begin
                tbl_mem[tbl_addr] <= q_head.prob;
            end
            tbl_rd_reg <= tbl_mem[tbl_addr];
        end
    end

    // unwritten entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tbl_vld_reg <= '0;
            tbl_hit_reg <= 1'b0;
        end else if (q_pop) begin
            if (is_twrite) begin
                tbl_vld_reg[tbl_addr] <= 1'b1;
            end
            tbl_hit_reg <= tbl_vld_reg[tbl_addr];
        end
    end

    // stage 1: class range, product, centre/size to corners in raw mode
    assign s1_cls_ok = !s1_reg.cls[VAL_W-1]
                    && (s1_reg.cls < VAL_W'(cfg.class_count))
                    && (s1_reg.cls < VAL_W'(NUM_CLASSES));
    assign c0e = CORNER_W'(s1_reg.c0);
    assign c1e = CORNER_W'(s1_reg.c1);
    assign c2e = CORNER_W'(s1_reg.c2);
    assign c3e = CORNER_W'(s1_reg.c3);

    always_comb begin
        s2_next.kind   = s1_reg.kind;
        s2_next.last   = s1_reg.last;
        s2_next.raw    = s1_reg.raw;
        s2_next.cls_ok = s1_cls_ok;
        s2_next.thr    = tbl_hit_reg ? tbl_rd_reg : '0;
        s2_next.prod   = PROD_W'(s1_reg.obj) * PROD_W'(s1_reg.prob);
        s2_next.obj    = s1_reg.obj;
        s2_next.conf   = s1_reg.conf;
        s2_next.cls    = s1_reg.cls[CLS_W-1:0];
        if (s1_reg.raw) begin
            // floor halving keeps width exact
            s2_next.x1 = c0e - (c2e >>> 1);
            s2_next.y1 = c1e - (c3e >>> 1);
            s2_next.x2 = c0e - (c2e >>> 1) + c2e;
            s2_next.y2 = c1e - (c3e >>> 1) + c3e;
        end else begin
            s2_next.x1 = c0e;
            s2_next.y1 = c1e;
            s2_next.x2 = c2e;
            s2_next.y2 = c3e;
        end
    end

    // stage 2: confidence, keep decision, clamp corners
    assign conf_raw = PROB_W'((s2_reg.prod + ROUND_HALF) >> 16);
    assign lim_x    = COORD_W'(cfg.net_width) << COORD_FRAC_BITS;
    assign lim_y    = COORD_W'(cfg.net_height) << COORD_FRAC_BITS;

    always_comb begin
        if (s2_reg.raw) begin
            drop = (s2_reg.obj < cfg.objectness_min) || !s2_reg.cls_ok
                || (conf_raw < s2_reg.thr);
        end else begin
            drop = !s2_reg.cls_ok || (s2_reg.conf < $signed(VAL_W'(s2_reg.thr)));
        end
        s3_next.last  = s2_reg.last;
        s3_next.keep  = (s2_reg.kind == ENT_ROW) && !drop;
        s3_next.l     = clamp_coord(s2_reg.x1, lim_x);
        s3_next.t     = clamp_coord(s2_reg.y1, lim_y);
        s3_next.r     = clamp_coord(s2_reg.x2, lim_x);
        s3_next.b     = clamp_coord(s2_reg.y2, lim_y);
        s3_next.score = s2_reg.raw ? conf_raw : sat_prob(s2_reg.conf);
        s3_next.cls   = s2_reg.cls;
    end

    // stage 3: size and the one-pixel minimum
    assign dw     = $signed({1'b0, s3_reg.r}) - $signed({1'b0, s3_reg.l});
    assign dh     = $signed({1'b0, s3_reg.b}) - $signed({1'b0, s3_reg.t});
    assign box_ok = s3_reg.keep && !dw[COORD_W] && !dh[COORD_W]
                 && (dw >= $signed(MIN_SIZE)) && (dh >= $signed(MIN_SIZE));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg   <= q_pop && !is_twrite;
            s2_vld_reg   <= s1_vld_reg;
            s3_vld_reg   <= s2_vld_reg;
            m_tvalid_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg      <= q_head;
            s2_reg      <= s2_next;
            s3_reg      <= s3_next;
            m_tlast_reg <= s3_reg.last;
            m_box_reg   <= box_ok;
            if (box_ok) begin
                m_tdata_reg <= {s3_reg.cls, s3_reg.score, dh[COORD_W-1:0],
                                dw[COORD_W-1:0], s3_reg.t, s3_reg.l};
            end else begin
                m_tdata_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_box_reg;

    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_box_reg) |-> (m_tdata_reg == '0))
        else $error("dropped row carries non-zero fields");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> ($stable(s3_vld_reg) && $stable(s2_vld_reg)))
        else $error("pipeline moved while the output was stalled");

    a_stall_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !q_pop)
        else $error("queue popped while the output was stalled");

endmodule

`default_nettype wire

// ----- hw/rtl/detection_row_box_filter.sv -----
// Top level of the detection row box filter: configuration registers and
// the front end, queue and back end. Depends on drbf_pkg and its submodules.
//
//   port group | dir | carries
//   s_*        | in  | tensor elements and threshold writes, one word per cycle
//   m_*        | out | one result word per finished row (or short final row)
//   cfg_*      | in  | register writes, index 0..4, no read-back
//
// An element is taken every cycle while the four-word queue has room; the
// row argmax is the only loop and advances one class score per cycle.
// A row's result passes through the queue and the back-end registers.
// aresetn is synchronous: it clears the row position, queue, pipeline valids
// and the threshold-table valid bits; unwritten table entries read as zero.
// A stalled m_tready freezes the back end; the front keeps taking words
// until the queue fills.
`default_nettype none

module detection_row_box_filter (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [drbf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [drbf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // value[23:0], class_slot[30:24], threshold_value[47:31]
    input  wire logic [drbf_pkg::S_TDATA_W-1:0]       s_tdata,
    input  wire logic                                 s_tlast,
    // req_type[0]
    input  wire logic [0:0]                           s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // box_left[15:0], box_top[31:16], box_width[47:32], box_height[63:48],
    // score[80:64], class_idx[87:81]
    output logic [drbf_pkg::M_TDATA_W-1:0]            m_tdata,
    output logic                                      m_tlast,
    // box_valid[0]
    output logic [0:0]                                m_tuser
);
    import drbf_pkg::*;

    cfg_t     cfg_reg;
    logic     s_accept;
    logic     push;
    row_ent_t push_ent;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;
    row_ent_t q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.raw_mode       <= 1'b0;
            cfg_reg.net_width      <= 12'd640;
            cfg_reg.net_height     <= 12'd640;
            cfg_reg.class_count    <= CLS_W'(80);
            cfg_reg.objectness_min <= PROB_W'(6554);
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_CHANNEL_MODE: cfg_reg.raw_mode       <= cfg_wdata[0];
                REG_NET_WIDTH:    cfg_reg.net_width      <= cfg_wdata[11:0];
                REG_NET_HEIGHT:   cfg_reg.net_height     <= cfg_wdata[11:0];
                REG_CLASS_COUNT:  cfg_reg.class_count    <= cfg_wdata[CLS_W-1:0];
                REG_OBJ_MIN:      cfg_reg.objectness_min <= cfg_wdata[PROB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    drbf_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .raw_mode        (cfg_reg.raw_mode),
        .s_accept        (s_accept),
        .req_type        (s_tuser[0]),
        .value           ($signed(s_tdata[23:0])),
        .last_of_tensor  (s_tlast),
        .class_slot      (s_tdata[30:24]),
        .threshold_value (s_tdata[47:31]),
        .push            (push),
        .push_ent        (push_ent)
    );

    drbf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_ent (push_ent),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    drbf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
